>>> hdl/dnle_pkg.sv
package dnle_pkg;

    // Request codes carried in req_type
    localparam logic [1:0] REQ_CHAR = 2'd0;
    localparam logic [1:0] REQ_LAST = 2'd1;
    localparam logic [1:0] REQ_END  = 2'd2;

    localparam logic [7:0] DOT_CHAR = 8'h2E;
    localparam logic [7:0] TERM_BYTE = 8'h00;

    typedef enum logic {
        ST_IDLE,
        ST_FLUSH
    } t_state;

    // Per-cell control: capture the broadcast character, or take the neighbor's byte
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

>>> hdl/dnle_if.sv
interface dnle_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] char_byte;

    modport source (output valid, output req_type, output char_byte, input ready);
    modport sink   (input valid, input req_type, input char_byte, output ready);
endinterface

interface dnle_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       label_too_long;

    modport source (output valid, output out_byte, output last_of_run,
                    output label_too_long, input ready);
    modport sink   (input valid, input out_byte, input last_of_run,
                    input label_too_long, output ready);
endinterface

>>> hdl/dnle_cell.sv
module dnle_cell
    import dnle_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctl  i_ctl,
    input  logic [7:0] i_char,
    input  logic [7:0] i_next,
    output logic [7:0] o_data
);

    logic [7:0] r_data;

    // Load wins; a cell is never loaded while the chain drains
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_data <= i_char;
        end else if (i_ctl.shift) begin
            r_data <= i_next;
        end
    end

    assign o_data = r_data;

endmodule

>>> hdl/dns_name_label_encoder.sv
// DNS name label encoder: dotted name in, length-prefixed wire labels out.
// Input channel i_in (valid/ready) carries one transaction per character:
// req_type REQ_CHAR for a character, REQ_LAST for the name's last character,
// REQ_END for the end-of-name marker (char_byte ignored); code 3 is dropped.
// Output channel o_out (valid/ready) carries one byte per transaction with
// last_of_run on the final byte caused by an input transaction and
// label_too_long on the zero terminator when a label was truncated.
// A byte caused by an input is registered and shows on o_out in the cycle after accept.
// A plain character is only stored. A dot or last character sends the
// label's length byte (L for a label of L bytes) on accept, then the cell chain
// shifts one label byte to the head per cycle while o_out is not stalled.
// The label bytes live in a row of MAX_LABEL_LEN cells; a new character is
// written into the cell addressed by the fill count and drained from cell 0.
// Reset (synchronous, active low) clears the fill count, the overflow flag,
// the state and the output valid flag; the output payload and cell contents are not cleared.
// A stalled receiver holds the output register; the block then takes no new
// input until the waiting byte is taken.
module dns_name_label_encoder
    import dnle_pkg::*;
#(
    parameter int MAX_LABEL_LEN = 63
)(
    input  logic       i_clk,
    input  logic       i_rst_n,
    dnle_in_if.sink    i_in,
    dnle_out_if.source o_out
);

    localparam int CNT_W = $clog2(MAX_LABEL_LEN + 1);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_ovf, n_ovf;
    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    logic               r_out_last;
    logic               r_out_err;

    logic               push;
    logic [7:0]         push_byte;
    logic               push_last;
    logic               push_err;
    logic               can_push;
    logic               accept;
    logic               append;
    logic               shift;

    t_cell_ctl          cell_ctl  [MAX_LABEL_LEN];
    logic [7:0]         cell_data [MAX_LABEL_LEN];

    // Output slot is free when empty or being taken this cycle
    assign can_push   = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE) && can_push;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ovf     = r_ovf;
        push      = 1'b0;
        push_byte = TERM_BYTE;
        push_last = 1'b0;
        push_err  = 1'b0;
        append    = 1'b0;
        shift     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_in.req_type)
                        REQ_END: begin
                            // Terminator, then start a fresh name
                            push      = 1'b1;
                            push_byte = TERM_BYTE;
                            push_last = 1'b1;
                            push_err  = r_ovf;
                            n_count   = '0;
                            n_ovf     = 1'b0;
                        end
                        REQ_CHAR, REQ_LAST: begin
                            if (i_in.char_byte == DOT_CHAR) begin
                                // Flush current label, possibly empty
                                push      = 1'b1;
                                push_byte = 8'(r_count);
                                push_last = (r_count == '0);
                                if (r_count != '0) begin
                                    n_state = ST_FLUSH;
                                end
                            end else begin
                                if (r_count < CNT_W'(MAX_LABEL_LEN)) begin
                                    append  = 1'b1;
                                    n_count = r_count + 1'b1;
                                end else begin
                                    n_ovf = 1'b1;
                                end
                                if (i_in.req_type == REQ_LAST) begin
                                    // Label is never empty here
                                    push      = 1'b1;
                                    push_byte = 8'(n_count);
                                    n_state   = ST_FLUSH;
                                end
                            end
                        end
                        default: begin
                            // Unused request code: drop
                        end
                    endcase
                end
            end
            ST_FLUSH: begin
                if (can_push) begin
                    push      = 1'b1;
                    push_byte = cell_data[0];
                    push_last = (r_count == CNT_W'(1));
                    shift     = 1'b1;
                    n_count   = r_count - 1'b1;
                    if (r_count == CNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload: hold while stalled
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out_byte <= push_byte;
            r_out_last <= push_last;
            r_out_err  <= push_err;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.out_byte       = r_out_byte;
    assign o_out.last_of_run    = r_out_last;
    assign o_out.label_too_long = r_out_err;

    // Cell chain: cell i loads when the fill count points at it, all shift toward cell 0
    for (genvar i = 0; i < MAX_LABEL_LEN; i++) begin : g_cell
        logic [7:0] next_data;

        assign cell_ctl[i].load  = append && (r_count == CNT_W'(i));
        assign cell_ctl[i].shift = shift;

        if (i == MAX_LABEL_LEN - 1) begin : g_tail
            assign next_data = 8'h00;
        end else begin : g_body
            assign next_data = cell_data[i + 1];
        end

        dnle_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (cell_ctl[i]),
            .i_char (i_in.char_byte),
            .i_next (next_data),
            .o_data (cell_data[i])
        );
    end

    // Draining a label always has at least one byte left
    a_flush_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FLUSH |-> r_count != '0)
        else $error("flush with empty label");

    // Fill count stays within the cell row
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_LABEL_LEN))
        else $error("fill count beyond label limit");

    // Error flag only on a terminator byte
    a_err_on_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.label_too_long |-> o_out.out_byte == TERM_BYTE
            && o_out.last_of_run)
        else $error("label_too_long off the terminator");

    // No new input while a label drains
    a_no_accept_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FLUSH |-> !i_in.ready)
        else $error("input ready during flush");

    // Last label byte returns the block to idle with an empty label
    a_flush_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FLUSH && shift && r_count == CNT_W'(1)
            |=> r_state == ST_IDLE && r_count == '0)
        else $error("flush did not finish cleanly");

endmodule
